/* rtl/pov_column_timing_top_assert.svh */
// Assertion macros shared by the column timing RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef POV_COLUMN_TIMING_TOP_ASSERT_SVH
`define POV_COLUMN_TIMING_TOP_ASSERT_SVH

// Same-cycle implication
`define PCT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pov column timing: assertion failed");

// Next-cycle implication
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pov column timing: assertion failed");

`endif

/* rtl/pct_pkg.sv */
// Shared types, constants and tables for the column timing block.
// No dependencies.
package pct_pkg;

  localparam int CNT_W     = 16;
  localparam int SLOT_W    = 4;
  localparam int DELAY_W   = 17;
  localparam int DEG_W     = 14;
  localparam int SPEED_W   = 16;
  localparam int OFFSET_W  = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = DIV_NUM_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SDLY_W    = DIV_NUM_W + 2;

  localparam logic [DIV_NUM_W-1:0] SPEED_NUM = 26'd60000000;
  localparam logic [DIV_NUM_W-1:0] PA_NUM    = 26'd34600000;
  localparam logic [DIV_NUM_W-1:0] PB_NUM    = 26'd17600000;
  localparam logic [DIV_DEN_W-1:0] TICK_US   = 20'd13;
  localparam logic [8:0]           DEG_PER_REV = 9'd360;

  // floor(x/60) = (x * ceil(2^22/60)) >> 22, exact for any 16 bit x
  localparam logic [16:0] RECIP_60    = 17'd69906;
  localparam int          RECIP_60_SH = 22;
  localparam int          DEG_QUO_W   = 11;

  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
  localparam logic [DEG_W-1:0]   DEG_MAX   = '1;

  localparam logic [SLOT_W-1:0] COL_LAST   = 4'd13;
  localparam logic [SLOT_W-1:0] SLOT_START = 4'd14;

  localparam logic [SPEED_W-1:0]  LIMIT_RST    = 16'd2000;
  localparam logic [SPEED_W-1:0]  FALLBACK_RST = 16'd1617;
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 12'd690;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FALLBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DEG,
    ST_UPD,
    ST_PUT
  } pct_state_e;

  typedef enum logic [2:0] {
    OP_SPEED,
    OP_DEG,
    OP_AVG,
    OP_COL,
    OP_PA,
    OP_PB
  } pct_op_e;

  typedef struct packed {
    logic              in_load;
    logic              div_start;
    logic              capture;
    logic              win_upd;
    logic              out_load;
    pct_op_e           op;
    logic [SLOT_W-1:0] col;
  } pct_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } pct_sts_t;

  // Column numerators, c_i * 62500
  function automatic logic [DIV_NUM_W-1:0] col_k(input logic [SLOT_W-1:0] idx);
    logic [DIV_NUM_W-1:0] k;
    case (idx)
      4'd0:    k = 26'd1100000;
      4'd1:    k = 26'd1138125;
      4'd2:    k = 26'd1179375;
      4'd3:    k = 26'd1223125;
      4'd4:    k = 26'd1270625;
      4'd5:    k = 26'd1321875;
      4'd6:    k = 26'd1377500;
      4'd7:    k = 26'd1438125;
      4'd8:    k = 26'd1504375;
      4'd9:    k = 26'd1576875;
      4'd10:   k = 26'd1656875;
      4'd11:   k = 26'd1745625;
      4'd12:   k = 26'd1844375;
      4'd13:   k = 26'd1955625;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic signed [4:0] col_off(input logic [SLOT_W-1:0] idx);
    logic signed [4:0] o;
    case (idx)
      4'd0:    o = 5'sd12;
      4'd1:    o = 5'sd3;
      4'd2:    o = 5'sd3;
      4'd3:    o = 5'sd3;
      4'd4:    o = 5'sd3;
      4'd5:    o = 5'sd3;
      4'd6:    o = 5'sd2;
      4'd7:    o = 5'sd1;
      4'd8:    o = 5'sd0;
      4'd9:    o = -5'sd2;
      4'd10:   o = -5'sd2;
      4'd11:   o = -5'sd4;
      4'd12:   o = -5'sd4;
      4'd13:   o = -5'sd4;
      default: o = 5'sd0;
    endcase
    return o;
  endfunction

  function automatic logic [DELAY_W-1:0] clamp_delay(input logic signed [SDLY_W-1:0] v);
    logic [DELAY_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SDLY_W-DELAY_W){1'b0}}, DELAY_MAX})) begin
      r = DELAY_MAX;
    end else begin
      r = v[DELAY_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/pct_in_if.sv */
// Capture channel: one revolution period per transaction.
// Depends on pct_pkg.
interface pct_in_if
  import pct_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capture_count;

  modport source (output valid, output capture_count, input ready);
  modport sink   (input valid, input capture_count, output ready);
endinterface

/* rtl/pct_out_if.sv */
// Result channel: one column or start delay per transaction.
// Depends on pct_pkg.
interface pct_out_if
  import pct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic [DELAY_W-1:0] delay_us;
  logic               last;

  modport source (output valid, output slot, output delay_us, output last, input ready);
  modport sink   (input valid, input slot, input delay_us, input last, output ready);
endinterface

/* rtl/pov_column_timing_top.sv */
// Channel   Dir  Transaction
// cap_i     in   capture_count: one revolution period in 13 us ticks
// res_o     out  slot, delay_us, last: 14 column delays then the start delay
// cfg_*     in   write of speed_limit, speed_fallback or start_offset
//
// One revolution runs 18 divisions through a single radix-4 divider, along with
// the accept, degree, window update and 15 result writes.
// A new capture is taken once the start delay has been handed to the output
// register. Output back-pressure stalls the sequencer at each result.
// Reset clears the averaging window and restores the register defaults.
// Depends on pct_pkg, pct_in_if, pct_out_if, pct_ctrl and pct_datapath.
module pov_column_timing_top
  import pct_pkg::*;
#(
  parameter int WINDOW_LEN = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pct_in_if.sink               cap_i,
  pct_out_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  pct_cmd_t cmd;
  pct_sts_t sts;

  pct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cap_i.valid),
    .in_ready_o (cap_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pct_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cnt_i       (cap_i.capture_count),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .slot_o      (res_o.slot),
    .delay_o     (res_o.delay_us),
    .last_o      (res_o.last)
  );

endmodule

/* rtl/pct_div.sv */
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on pct_pkg.
module pct_div
  import pct_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic                 busy_q, done_q;

  // quotient bits shift in as the dividend shifts out
  always_comb begin
    logic [DIV_DEN_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial = {rem_d, quo_d[DIV_NUM_W-1]};
      quo_d = {quo_d[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/pct_datapath.sv */
// Datapath: config registers, speed and averaging window, operand selection,
// delay arithmetic and the output register. Depends on pct_pkg and pct_div.
`include "pov_column_timing_top_assert.svh"
module pct_datapath
  import pct_pkg::*;
#(
  parameter int WINDOW_LEN = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [CNT_W-1:0]     cnt_i,
  input  pct_cmd_t             cmd_i,
  output pct_sts_t             sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [DELAY_W-1:0]   delay_o,
  output logic                 last_o
);

  localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = $clog2(WINDOW_LEN * (2 ** DEG_W - 1) + 1);

  logic [SPEED_W-1:0]  limit_q, fallback_q;
  logic [OFFSET_W-1:0] offset_q;

  logic [DEG_W-1:0]    win_q [WINDOW_LEN];
  logic [PTR_W-1:0]    pos_q;
  logic [FILL_W-1:0]   fill_q;
  logic [SUM_W-1:0]    sum_q;

  logic [CNT_W-1:0]     cnt_q;
  logic [SPEED_W-1:0]   speed_q;
  logic [DEG_W-1:0]     deg_q;
  logic [DEG_W-1:0]     avg_q;
  logic [DIV_NUM_W-1:0] pa_q;
  logic [DELAY_W-1:0]   res_q;

  logic                 out_valid_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [DELAY_W-1:0]   delay_q;
  logic                 last_q;

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic                 div_busy, div_done;
  logic [32:0]          spd_prod;
  logic [DEG_QUO_W-1:0] deg_quo;
  logic [19:0]          deg_prod;
  logic [DEG_W-1:0]     deg_sat;
  logic signed [4:0]    col_off_v;
  logic signed [SDLY_W-1:0] col_v, start_v;
  logic [DELAY_W-1:0]   col_dly, start_dly;
  logic [DIV_DEN_W-1:0] avg_den;

  assign avg_den = {{(DIV_DEN_W-DEG_W){1'b0}}, avg_q};

  always_comb begin
    case (cmd_i.op)
      OP_SPEED: begin
        num = SPEED_NUM;
        den = DIV_DEN_W'(cnt_q) * TICK_US;
      end
      OP_AVG: begin
        num = {{(DIV_NUM_W-SUM_W){1'b0}}, sum_q};
        den = {{(DIV_DEN_W-FILL_W){1'b0}}, fill_q};
      end
      OP_COL: begin
        num = col_k(cmd_i.col);
        den = avg_den;
      end
      OP_PA: begin
        num = PA_NUM;
        den = avg_den;
      end
      OP_PB: begin
        num = PB_NUM;
        den = avg_den;
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  pct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // speed/60 by reciprocal multiply; the quotient stays below 1093
  assign spd_prod = 33'(speed_q) * 33'(RECIP_60);
  assign deg_quo  = spd_prod[RECIP_60_SH +: DEG_QUO_W];
  assign deg_prod = 20'(deg_quo) * 20'(DEG_PER_REV);
  assign deg_sat  = (deg_prod > 20'(DEG_MAX)) ? DEG_MAX : deg_prod[DEG_W-1:0];

  assign col_off_v = col_off(cmd_i.col);
  assign col_v = $signed({2'b00, quo})
               + $signed({{(SDLY_W-5){col_off_v[4]}}, col_off_v});
  assign start_v = $signed({2'b00, pa_q})
                 - $signed({3'b000, quo[DIV_NUM_W-1:1]})
                 - $signed({{(SDLY_W-OFFSET_W){1'b0}}, offset_q});
  // zero average: the whole run saturates
  assign col_dly   = (avg_q == '0) ? DELAY_MAX : clamp_delay(col_v);
  assign start_dly = (avg_q == '0) ? DELAY_MAX : clamp_delay(start_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LIMIT_RST;
      fallback_q <= FALLBACK_RST;
      offset_q   <= OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED_LIMIT:    limit_q    <= cfg_data_i[SPEED_W-1:0];
        CFG_SPEED_FALLBACK: fallback_q <= cfg_data_i[SPEED_W-1:0];
        CFG_START_OFFSET:   offset_q   <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.win_upd) begin
      win_q[pos_q] <= deg_q;
      sum_q        <= sum_q - SUM_W'(win_q[pos_q]) + SUM_W'(deg_q);
      pos_q        <= (pos_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
      if (fill_q != FILL_W'(WINDOW_LEN)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cnt_q <= cnt_i;
    end
    if (cmd_i.capture) begin
      case (cmd_i.op)
        OP_SPEED: begin
          if (cnt_q == '0 || quo > {{(DIV_NUM_W-SPEED_W){1'b0}}, limit_q}) begin
            speed_q <= fallback_q;
          end else begin
            speed_q <= quo[SPEED_W-1:0];
          end
        end
        OP_DEG:  deg_q <= deg_sat;
        OP_AVG:  avg_q <= quo[DEG_W-1:0];
        OP_COL:  res_q <= col_dly;
        OP_PA:   pa_q  <= quo;
        OP_PB:   res_q <= start_dly;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_q  <= (cmd_i.op == OP_PB) ? SLOT_START : cmd_i.col;
      delay_q <= res_q;
      last_q  <= (cmd_i.op == OP_PB);
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign delay_o     = delay_q;
  assign last_o      = last_q;

  `PCT_ASSERT(fill_in_range, 1'b1, fill_q <= FILL_W'(WINDOW_LEN))
  `PCT_ASSERT(pos_in_range, 1'b1, {1'b0, pos_q} < (PTR_W + 1)'(WINDOW_LEN))
  `PCT_ASSERT(avg_den_nonzero, cmd_i.div_start && cmd_i.op == OP_AVG, fill_q != '0)
  `PCT_ASSERT_NEXT(div_runs_after_start, cmd_i.div_start, div_busy)

endmodule

/* rtl/pct_ctrl.sv */
// Sequencer: steps one revolution through its divisions and result writes.
// Depends on pct_pkg.
`include "pov_column_timing_top_assert.svh"
module pct_ctrl
  import pct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pct_sts_t sts_i,
  output pct_cmd_t cmd_o
);

  pct_state_e        state_q, state_d;
  pct_op_e           op_q, op_d;
  logic [SLOT_W-1:0] col_q, col_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    col_d   = col_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = OP_SPEED;
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_RUN;
      ST_RUN: begin
        if (sts_i.div_done) begin
          case (op_q)
            OP_SPEED: begin
              op_d    = OP_DEG;
              state_d = ST_DEG;
            end
            OP_AVG: begin
              op_d    = OP_COL;
              col_d   = '0;
              state_d = ST_START;
            end
            OP_PA: begin
              op_d    = OP_PB;
              state_d = ST_START;
            end
            OP_COL, OP_PB: state_d = ST_PUT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DEG: state_d = ST_UPD;
      ST_UPD: begin
        op_d    = OP_AVG;
        state_d = ST_START;
      end
      ST_PUT: begin
        if (sts_i.out_free) begin
          if (op_q == OP_PB) begin
            state_d = ST_IDLE;
          end else if (col_q == COL_LAST) begin
            op_d    = OP_PA;
            state_d = ST_START;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = ST_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.in_load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_start   = (state_q == ST_START);
    cmd_o.capture     = ((state_q == ST_RUN) && sts_i.div_done) || (state_q == ST_DEG);
    cmd_o.win_upd     = (state_q == ST_UPD);
    cmd_o.out_load    = (state_q == ST_PUT) && sts_i.out_free;
    cmd_o.op          = op_q;
    cmd_o.col         = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SPEED;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      col_q   <= col_d;
    end
  end

  `PCT_ASSERT(load_only_when_free, cmd_o.out_load, sts_i.out_free)
  `PCT_ASSERT(col_in_range, 1'b1, col_q <= COL_LAST)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for pov_column_timing_top: directed table, then random captures.
// Column and start delays are predicted in-bench and compared per transaction.
// Depends on pct_pkg, pct_in_if, pct_out_if and the column timing RTL.
module tb_top;
  import pct_pkg::*;

  localparam int WIN_LEN     = 20;
  localparam int N_COLS      = 14;
  localparam int N_DIR       = 24;
  localparam int LONG_HOLD   = 1500;
  localparam int CFG_GAP     = 16;
  localparam int TAIL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic {ROW_CFG, ROW_CAP} row_kind_e;
  // Hand-typed expectations for rows whose answer is plain from the arithmetic
  typedef enum logic [1:0] {TYP_NONE, TYP_ALL_SAT, TYP_START_SAT, TYP_START_ZERO} typed_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
    typed_e                typ;
  } stim_row_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] delay_us;
    logic               last;
  } timing_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  pct_in_if  cap_if ();
  pct_out_if res_if ();

  pov_column_timing_top #(
    .WINDOW_LEN (WIN_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Register shadow and averaging window of the predictor
  logic [SPEED_W-1:0]  lim_r = LIMIT_RST;
  logic [SPEED_W-1:0]  fb_r  = FALLBACK_RST;
  logic [OFFSET_W-1:0] off_r = OFFSET_RST;
  logic [DEG_W-1:0]    win_deg [WIN_LEN];
  int                  win_pos;
  int                  win_fill;
  int unsigned         win_sum;

  int unsigned col_num [N_COLS] = '{1100000, 1138125, 1179375, 1223125, 1270625, 1321875,
                                    1377500, 1438125, 1504375, 1576875, 1656875, 1745625,
                                    1844375, 1955625};
  int          col_adj [N_COLS] = '{12, 3, 3, 3, 3, 3, 2, 1, 0, -2, -2, -4, -4, -4};

  timing_t delay_q [$];

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int n_caps    = 0;
  int n_results = 0;
  int n_writes  = 0;
  int n_mism    = 0;

  // idx is unused on capture rows
  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_CFG, CFG_SPEED_FALLBACK, 16'd0,     TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd0,     TYP_ALL_SAT},    // zero average
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd0,     TYP_ALL_SAT},
    '{ROW_CFG, CFG_SPEED_FALLBACK, 16'd1617,  TYP_NONE},
    '{ROW_CFG, CFG_SPEED_LIMIT,    16'd65535, TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'hFFFF,  TYP_START_SAT},  // avg 120
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd1,     TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd77,    TYP_NONE},       // degree overflow
    '{ROW_CFG, CFG_SPEED_LIMIT,    16'd0,     TYP_NONE},
    '{ROW_CFG, CFG_SPEED_FALLBACK, 16'd65535, TYP_NONE},
    '{ROW_CFG, CFG_START_OFFSET,   16'd4095,  TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'h5555,  TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'hAAAA,  TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'hFFFF,  TYP_START_ZERO}, // avg above 6300
    '{ROW_CFG, CFG_START_OFFSET,   16'd0,     TYP_NONE},
    '{ROW_CFG, CFG_SPEED_LIMIT,    16'd1538,  TYP_NONE},
    '{ROW_CFG, CFG_SPEED_FALLBACK, 16'd1617,  TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd3000,  TYP_NONE},       // speed equals limit
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd2990,  TYP_NONE},       // just over limit
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd4615,  TYP_NONE},
    '{ROW_CFG, CFG_SPEED_LIMIT,    16'd2000,  TYP_NONE},
    '{ROW_CFG, CFG_START_OFFSET,   16'd690,   TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd2308,  TYP_NONE},
    '{ROW_CAP, CFG_SPEED_LIMIT,    16'd1,     TYP_NONE}
  };

  function automatic logic [DELAY_W-1:0] sat_delay(input longint v);
    if (v < 0) return '0;
    if (v > longint'(DELAY_MAX)) return DELAY_MAX;
    return v[DELAY_W-1:0];
  endfunction

  // One capture in, fifteen delays out; window state advances as in the block
  function automatic void predict_timing(input logic [CNT_W-1:0] cnt, input typed_e typ);
    int unsigned spd;
    int unsigned deg;
    int unsigned avg;
    longint      dly;
    timing_t     t;
    if (cnt == '0) begin
      spd = fb_r;
    end else begin
      spd = 32'd60000000 / (32'd13 * cnt);
      if (spd > lim_r) spd = fb_r;
    end
    deg = (spd / 60) * 360;
    if (deg > DEG_MAX) deg = DEG_MAX;
    win_sum = win_sum - win_deg[win_pos] + deg;
    win_deg[win_pos] = deg[DEG_W-1:0];
    win_pos = (win_pos == WIN_LEN - 1) ? 0 : win_pos + 1;
    if (win_fill < WIN_LEN) win_fill++;
    avg = win_sum / win_fill;

    for (int i = 0; i < N_COLS; i++) begin
      if (avg == 0) begin
        dly = longint'(DELAY_MAX);
      end else begin
        dly = longint'(col_num[i] / avg) + col_adj[i];
      end
      t.slot     = SLOT_W'(i);
      t.delay_us = sat_delay(dly);
      t.last     = 1'b0;
      if (typ == TYP_ALL_SAT) t.delay_us = 17'd131071;
      delay_q.push_back(t);
    end

    if (avg == 0) begin
      dly = longint'(DELAY_MAX);
    end else begin
      dly = longint'(34600000 / avg) - longint'((17600000 / avg) / 2) - longint'(off_r);
    end
    t.slot     = SLOT_START;
    t.delay_us = sat_delay(dly);
    t.last     = 1'b1;
    case (typ)
      TYP_ALL_SAT, TYP_START_SAT: t.delay_us = 17'd131071;
      TYP_START_ZERO:             t.delay_us = 17'd0;
      default: ;
    endcase
    delay_q.push_back(t);
  endfunction

  function automatic logic [CNT_W-1:0] random_capture();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CNT_W'($urandom_range(0, 65535));
      4:       return CNT_W'(1) << $urandom_range(0, CNT_W - 1);
      default: return CNT_W'($urandom_range(1500, 12000));  // plausible rotor speeds
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPEED_LIMIT:    lim_r = val;
      CFG_SPEED_FALLBACK: fb_r  = val;
      CFG_START_OFFSET:   off_r = val[OFFSET_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic offer_capture(input logic [CNT_W-1:0] cnt, input typed_e typ);
    if (!steady && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      cap_if.valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
    @(negedge clk_i);
    cap_if.valid         <= 1'b1;
    cap_if.capture_count <= cnt;
    @(posedge clk_i);
    while (!cap_if.ready) @(posedge clk_i);
    predict_timing(cnt, typ);
    n_caps++;
  endtask

  // Idle the capture side and let every outstanding delay come back
  task automatic drain();
    @(negedge clk_i);
    cap_if.valid <= 1'b0;
    while (delay_q.size() != 0) @(posedge clk_i);
    repeat (CFG_GAP) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input logic [CFG_W-1:0] lim,
                           input logic [CFG_W-1:0] fb, input logic [OFFSET_W-1:0] off,
                           input bit with_hold);
    drain();
    write_reg(CFG_SPEED_LIMIT, lim);
    write_reg(CFG_SPEED_FALLBACK, fb);
    write_reg(CFG_START_OFFSET, CFG_W'(off));
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == 12) hold_req = 1'b1;
      offer_capture(random_capture(), TYP_NONE);
    end
    drain();
  endtask

  // Result side ready: random bursts, one long hold-off on request
  initial begin : rx_ready
    int n;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (steady) begin
        res_if.ready <= 1'b1;
      end else begin
        n = $urandom_range(1, 10);
        res_if.ready <= ($urandom_range(0, 2) != 0);
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : res_check
    timing_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_results++;
      if (delay_q.size() == 0) begin
        n_mism++;
        if (n_mism <= MAX_REPORTS)
          $display("%0t: unexpected transaction slot %0d delay %0d last %0b",
                   $realtime, res_if.slot, res_if.delay_us, res_if.last);
      end else begin
        want = delay_q.pop_front();
        if (res_if.slot !== want.slot || res_if.delay_us !== want.delay_us ||
            res_if.last !== want.last) begin
          n_mism++;
          if (n_mism <= MAX_REPORTS)
            $display("%0t: mismatch exp slot %0d delay %0d last %0b, got slot %0d delay %0d last %0b",
                     $realtime, want.slot, want.delay_us, want.last,
                     res_if.slot, res_if.delay_us, res_if.last);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("Timed out after %0d cycles, %0d delays outstanding", cyc, delay_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stim
    stim_row_t row;
    rst_ni               = 1'b0;
    cap_if.valid         = 1'b0;
    cap_if.capture_count = '0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_SPEED_LIMIT;
    cfg_data             = '0;
    for (int i = 0; i < WIN_LEN; i++) win_deg[i] = '0;
    win_pos  = 0;
    win_fill = 0;
    win_sum  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) begin
        if (cap_if.valid) drain();
        write_reg(row.idx, row.val);
      end else begin
        offer_capture(row.val, row.typ);
      end
    end

    run_phase(60, LIMIT_RST, FALLBACK_RST, OFFSET_RST, 1'b1);
    run_phase(55, 16'hFFFF, CFG_W'($urandom_range(0, 65535)),
              OFFSET_W'($urandom_range(0, 4095)), 1'b0);
    // fallback pinned to an extreme, mostly over a low limit
    run_phase(50, CFG_W'($urandom_range(0, 3000)),
              ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000, 12'hFFF, 1'b0);
    steady = 1'b1;
    run_phase(60, CFG_W'($urandom_range(1000, 4000)), CFG_W'($urandom_range(0, 2500)),
              12'h000, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d captures, %0d delay transactions, %0d register writes",
             n_caps, n_results, n_writes);
    $display("Mismatches %0d, delays still outstanding %0d", n_mism, delay_q.size());
    if (n_mism == 0 && delay_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
